// File: rtl/aes_pkg.sv
// Shared types, tables and GF(2^8) helpers for the AES-128 ECB/CBC cipher.
package aes_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int ROUNDS      = 10;
	localparam int KEY_WORDS   = 44;

	localparam logic [2:0] REG_KEY_HIGH   = 3'd0;
	localparam logic [2:0] REG_KEY_LOW    = 3'd1;
	localparam logic [2:0] REG_IV_HIGH    = 3'd2;
	localparam logic [2:0] REG_IV_LOW     = 3'd3;
	localparam logic [2:0] REG_CHAIN_MODE = 3'd4;
	localparam logic [2:0] REG_DIRECTION  = 3'd5;

	typedef logic [7:0]   byte_t;
	typedef logic [127:0] block_t;
	typedef logic [3:0]   rk_addr_t;
	typedef byte_t        byte_tbl_t [256];

	localparam byte_tbl_t SBOX = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic byte_tbl_t make_inv_sbox();
		byte_tbl_t t;
		for (int k = 0; k < 256; k++) begin
			t[SBOX[k]] = byte_t'(k);
		end
		return t;
	endfunction

	localparam byte_tbl_t INV_SBOX = make_inv_sbox();

	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c);
		byte_t a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	function automatic byte_t gm9(input byte_t a);
		return xtime(xtime(xtime(a))) ^ a;
	endfunction
	function automatic byte_t gm11(input byte_t a);
		return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
	endfunction
	function automatic byte_t gm13(input byte_t a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
	endfunction
	function automatic byte_t gm14(input byte_t a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		byte_t a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		return {gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3),
			gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3),
			gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3),
			gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3)};
	endfunction

	function automatic byte_t rcon(input logic [3:0] i);
		byte_t r;
		case (i)
			4'd0:    r = 8'h01;
			4'd1:    r = 8'h02;
			4'd2:    r = 8'h04;
			4'd3:    r = 8'h08;
			4'd4:    r = 8'h10;
			4'd5:    r = 8'h20;
			4'd6:    r = 8'h40;
			4'd7:    r = 8'h80;
			4'd8:    r = 8'h1b;
			4'd9:    r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/aes_key_exp.sv
// Iterative key expansion, one word per cycle, into the round key memory.
module aes_key_exp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  aes_pkg::block_t   key,
	input  aes_pkg::rk_addr_t rd_addr,
	output aes_pkg::block_t   rd_data,
	output logic              busy
);
	import aes_pkg::*;

	block_t      mem_q [ROUNDS + 1];
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [31:0] win_q [4];
	logic [31:0] t, rot, new_w;

	always_comb begin
		rot = {win_q[3][23:0], win_q[3][31:24]};
		t = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]}
			^ {rcon(cnt_q[5:2] - 4'd1), 24'h0};
		if (cnt_q < 6'd4) begin
			new_w = key[127 - 32 * cnt_q[1:0] -: 32];
		end else if (cnt_q[1:0] == 2'd0) begin
			new_w = win_q[0] ^ t;
		end else begin
			new_w = win_q[0] ^ win_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(KEY_WORDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= new_w;
			if (cnt_q[1:0] == 2'd3) begin
				mem_q[cnt_q[5:2]] <= {win_q[1], win_q[2], win_q[3], new_w};
			end
		end
		rd_data <= mem_q[rd_addr];
	end

	assign busy = busy_q;

endmodule

// File: rtl/aes_round.sv
// One forward or inverse AES round, shared across all ten rounds.
module aes_round (
	input  aes_pkg::block_t din,
	input  aes_pkg::block_t rk,
	input  logic            dec,
	input  logic            last,
	output aes_pkg::block_t dout
);
	import aes_pkg::*;

	byte_t  s [16];
	byte_t  ea [16];
	byte_t  eb [16];
	byte_t  da [16];
	byte_t  db [16];
	block_t e_sr, d_x, e_out, d_out;

	always_comb begin
		for (int j = 0; j < 16; j++) begin
			s[j] = din[127 - 8 * j -: 8];
		end
		for (int j = 0; j < 16; j++) begin
			ea[j] = SBOX[s[j]];
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				eb[r + 4 * c] = ea[r + 4 * ((c + r) % 4)];
				da[r + 4 * ((c + r) % 4)] = s[r + 4 * c];
			end
		end
		for (int j = 0; j < 16; j++) begin
			db[j] = INV_SBOX[da[j]];
			e_sr[127 - 8 * j -: 8] = eb[j];
			d_x[127 - 8 * j -: 8] = db[j] ^ rk[127 - 8 * j -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			e_out[127 - 32 * c -: 32] = last ? e_sr[127 - 32 * c -: 32]
				: mix_col(e_sr[127 - 32 * c -: 32]);
			d_out[127 - 32 * c -: 32] = last ? d_x[127 - 32 * c -: 32]
				: inv_mix_col(d_x[127 - 32 * c -: 32]);
		end
		e_out = e_out ^ rk;
	end

	assign dout = dec ? d_out : e_out;

endmodule

// File: rtl/aes128_ecb_cbc_cipher.sv
// Top level: AES-128 ECB/CBC cipher with register port and round sequencer.
//
// Input requests (in_valid/in_ready) carry one 16-byte block, a first_block
// flag and a valid byte count; each produces one result request on
// out_valid/out_ready. Key, IV, chaining mode and direction are set through
// the write port (cfg_we, cfg_index, cfg_data); the user must do so only
// while no block is in flight, which the block does not enforce. A block
// goes through the initial key addition, ten rounds in the single shared
// round unit and the hand-over to the output register; each round key is
// read in the cycle before its use. One block is worked on at a time and
// the next request is taken the cycle after the hand-over. Round keys sit
// in an 11-row memory filled one word per cycle, so after reset and after
// each key write in_ready stays low while start_q is set and while the
// schedule is expanded. If the receiver stalls, the finished block waits in
// the final stage until the output register frees up.
module aes128_ecb_cbc_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        first_block,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic [4:0]  valid_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	import aes_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_RND  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic        cbc_q, dec_q;
	logic        start_q, kx_busy;
	block_t      chain_q, xor_q, state_q, res_q, rk, rnd_out;
	block_t      cv, padded, blk;
	logic [1:0]  st_q;
	logic [3:0]  cnt_q;
	rk_addr_t    rd_addr;
	logic [4:0]  vb;
	logic        accept, fin_go;

	assign accept = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE) && !start_q && !kx_busy;
	assign fin_go = (st_q == ST_FIN) && (!out_valid || out_ready);

	always_comb begin
		blk = {block_high, block_low};
		cv = first_block ? {iv_high_q, iv_low_q} : chain_q;
		vb = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
		for (int j = 0; j < BLOCK_BYTES; j++) begin
			padded[127 - 8 * j -: 8] = (5'(j) < vb) ? blk[127 - 8 * j -: 8]
				: {3'b000, 5'd16 - vb};
		end
		case (st_q)
			ST_IDLE: rd_addr = dec_q ? rk_addr_t'(ROUNDS) : '0;
			ST_ADD:  rd_addr = dec_q ? rk_addr_t'(ROUNDS - 1) : 4'd1;
			ST_RND: begin
				if (cnt_q == 4'(ROUNDS)) begin
					rd_addr = '0;
				end else begin
					rd_addr = dec_q ? 4'(ROUNDS - 1) - cnt_q : cnt_q + 4'd1;
				end
			end
			default: rd_addr = '0;
		endcase
	end

	aes_key_exp u_key_exp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.key     ({key_high_q, key_low_q}),
		.rd_addr (rd_addr),
		.rd_data (rk),
		.busy    (kx_busy)
	);

	aes_round u_round (
		.din  (state_q),
		.rk   (rk),
		.dec  (dec_q),
		.last (cnt_q == 4'(ROUNDS)),
		.dout (rnd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			cbc_q      <= 1'b0;
			dec_q      <= 1'b0;
			start_q    <= 1'b1;
			chain_q    <= '0;
			st_q       <= ST_IDLE;
			cnt_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			start_q <= cfg_we && (cfg_index inside {REG_KEY_HIGH, REG_KEY_LOW});
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_HIGH:   key_high_q <= cfg_data;
					REG_KEY_LOW:    key_low_q  <= cfg_data;
					REG_IV_HIGH:    iv_high_q  <= cfg_data;
					REG_IV_LOW:     iv_low_q   <= cfg_data;
					REG_CHAIN_MODE: cbc_q      <= cfg_data[0];
					REG_DIRECTION:  dec_q      <= cfg_data[0];
					default: ;
				endcase
			end
			if (fin_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_ADD;
						if (dec_q && cbc_q) begin
							chain_q <= blk;
						end else begin
							chain_q <= cv;
						end
					end
				end
				ST_ADD: begin
					st_q  <= ST_RND;
					cnt_q <= 4'd1;
				end
				ST_RND: begin
					if (cnt_q == 4'(ROUNDS)) begin
						st_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						st_q <= ST_IDLE;
						if (cbc_q && !dec_q) begin
							chain_q <= state_q;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xor_q   <= cbc_q ? cv : '0;
			state_q <= dec_q ? blk : (padded ^ (cbc_q ? cv : '0));
		end else if (st_q == ST_ADD) begin
			state_q <= state_q ^ rk;
		end else if (st_q == ST_RND) begin
			state_q <= (dec_q && cnt_q == 4'(ROUNDS)) ? (rnd_out ^ xor_q) : rnd_out;
		end
		if (fin_go) begin
			res_q <= state_q;
		end
	end

	assign result_high = res_q[127:64];
	assign result_low  = res_q[63:0];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RND |-> (cnt_q >= 4'd1 && cnt_q <= 4'(ROUNDS)))
		else $error("round count out of range");

	a_no_accept_expand: assert property (@(posedge clk) disable iff (!arst_n)
		kx_busy |-> !in_ready)
		else $error("request taken during key expansion");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == ST_FIN)
		else $error("result raised outside final stage");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && out_valid && !out_ready) |=> st_q == ST_FIN)
		else $error("final stage left while output stalled");

endmodule

// File: dv/tb_aes128_ecb_cbc_cipher.sv
// Self-checking testbench for the AES-128 ECB/CBC cipher: directed table, then random traffic.
module tb_aes128_ecb_cbc_cipher;
	timeunit 1ns;
	timeprecision 1ps;
	import aes_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        first_block;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic [4:0]  valid_bytes;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_high;
	logic [63:0] result_low;

	aes128_ecb_cbc_cipher DUT (.*);

	typedef struct {
		logic        first;
		logic [63:0] bh;
		logic [63:0] bl;
		logic [4:0]  nvalid;
		logic        known;
		block_t      want;
	} request_t;

	// predictor state
	logic [31:0] rkey [KEY_WORDS];
	logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic        cbc_q, decrypt_q;
	block_t      chain_q;
	byte_t       inv_tbl [256];

	block_t cipher_fifo [$];
	int     mismatches;
	int     cycles;
	bit     sender_done;
	bit     long_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic byte_t gf_mul(byte_t a, byte_t b);
		byte_t r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				r ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return r;
	endfunction

	function automatic void build_schedule();
		logic [31:0] t;
		byte_t rc;
		rkey[0] = key_hi_q[63:32];
		rkey[1] = key_hi_q[31:0];
		rkey[2] = key_lo_q[63:32];
		rkey[3] = key_lo_q[31:0];
		rc = 8'h01;
		for (int i = 4; i < KEY_WORDS; i++) begin
			t = rkey[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
				t ^= {rc, 24'h0};
				rc = gf_mul(rc, 8'h02);
			end
			rkey[i] = rkey[i-4] ^ t;
		end
	endfunction

	function automatic void add_key(ref byte_t s [16], input int r);
		for (int j = 0; j < 16; j++)
			s[j] ^= rkey[4*r + j/4][31 - 8*(j%4) -: 8];
	endfunction

	function automatic void shift(ref byte_t s [16], input bit inv);
		byte_t t [16];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (inv)
					t[r + 4*((c + r) % 4)] = s[r + 4*c];
				else
					t[r + 4*c] = s[r + 4*((c + r) % 4)];
		s = t;
	endfunction

	function automatic void mix(ref byte_t s [16], input bit inv);
		byte_t m [4];
		byte_t col [4];
		byte_t acc;
		if (inv)
			m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else
			m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++)
				col[r] = s[4*c + r];
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++)
					acc ^= gf_mul(col[k], m[(k + 4 - r) % 4]);
				s[4*c + r] = acc;
			end
		end
	endfunction

	function automatic block_t cipher_block(logic first, logic [63:0] bh, logic [63:0] bl,
			logic [4:0] nv);
		byte_t s [16];
		block_t din, res;
		int n;
		if (first)
			chain_q = {iv_hi_q, iv_lo_q};
		din = {bh, bl};
		for (int j = 0; j < 16; j++)
			s[j] = din[127 - 8*j -: 8];
		if (!decrypt_q) begin
			n = (nv > 16) ? 16 : nv;
			for (int j = n; j < 16; j++)
				s[j] = byte_t'(16 - n);
			if (cbc_q)
				for (int j = 0; j < 16; j++)
					s[j] ^= chain_q[127 - 8*j -: 8];
			add_key(s, 0);
			for (int r = 1; r <= ROUNDS; r++) begin
				for (int j = 0; j < 16; j++)
					s[j] = SBOX[s[j]];
				shift(s, 1'b0);
				if (r != ROUNDS)
					mix(s, 1'b0);
				add_key(s, r);
			end
		end else begin
			add_key(s, ROUNDS);
			for (int r = ROUNDS; r >= 1; r--) begin
				shift(s, 1'b1);
				for (int j = 0; j < 16; j++)
					s[j] = inv_tbl[s[j]];
				add_key(s, r - 1);
				if (r != 1)
					mix(s, 1'b1);
			end
			if (cbc_q)
				for (int j = 0; j < 16; j++)
					s[j] ^= chain_q[127 - 8*j -: 8];
		end
		for (int j = 0; j < 16; j++)
			res[127 - 8*j -: 8] = s[j];
		if (cbc_q)
			chain_q = decrypt_q ? din : res;
		return res;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEY_HIGH: begin
				key_hi_q = val;
				build_schedule();
			end
			REG_KEY_LOW: begin
				key_lo_q = val;
				build_schedule();
			end
			REG_IV_HIGH:    iv_hi_q = val;
			REG_IV_LOW:     iv_lo_q = val;
			REG_CHAIN_MODE: cbc_q = val[0];
			REG_DIRECTION:  decrypt_q = val[0];
			default: ;
		endcase
	endtask

	task automatic send_block(request_t rq);
		block_t exp;
		int idle;
		idle = $urandom_range(0, 6);
		if (idle != 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid    <= 1'b1;
		first_block <= rq.first;
		block_high  <= rq.bh;
		block_low   <= rq.bl;
		valid_bytes <= rq.nvalid;
		do @(posedge clk); while (!in_ready);
		exp = cipher_block(rq.first, rq.bh, rq.bl, rq.nvalid);
		if (rq.known && exp !== rq.want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees: table %h model %h", rq.want, exp);
		end
		cipher_fifo.push_back(exp);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cipher_fifo.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_block(int chance_first);
		request_t rq;
		rq.first  = ($urandom_range(0, 99) < chance_first);
		rq.bh     = {$urandom, $urandom};
		rq.bl     = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0:       rq.nvalid = 5'd16;
			1:       rq.nvalid = 5'($urandom_range(17, 31));
			2:       rq.nvalid = 5'd0;
			default: rq.nvalid = 5'($urandom_range(1, 15));
		endcase
		rq.known = 1'b0;
		send_block(rq);
	endtask

	// receiver
	initial begin
		block_t got;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(0, 6)) @(posedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			out_ready <= 1'b0;
			got = {result_high, result_low};
			if (cipher_fifo.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				if (got !== cipher_fifo[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", cipher_fifo[0], got);
				end
				void'(cipher_fifo.pop_front());
			end
		end
	end

	// directed table: zero key after reset, then FIPS-197 example key under encrypt and decrypt
	request_t dir_tbl [$];

	initial begin
		for (int k = 0; k < 256; k++)
			inv_tbl[SBOX[k]] = byte_t'(k);
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_KEY_HIGH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		first_block = 1'b0;
		block_high  = '0;
		block_low   = '0;
		valid_bytes = 5'd16;
		mismatches  = 0;
		cycles      = 0;
		long_hold   = 1'b0;
		key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
		cbc_q = 1'b0; decrypt_q = 1'b0; chain_q = '0;
		build_schedule();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// zero key after reset: zero block, all-ones block and partial blocks
		dir_tbl = '{
			'{1'b0, 64'h0, 64'h0, 5'd16, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
			'{1'b1, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b0, '0},
			'{1'b0, 64'h0, 64'h0, 5'd0, 1'b0, '0},
			'{1'b0, 64'h0, 64'h0, 5'd1, 1'b0, '0},
			'{1'b0, 64'h0, 64'h0, 5'd15, 1'b0, '0},
			'{1'b0, 64'h0, 64'h0, 5'd31, 1'b0, '0}
		};
		foreach (dir_tbl[i])
			send_block(dir_tbl[i]);
		drain();

		write_reg(REG_KEY_HIGH, 64'h0001020304050607);
		write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		write_reg(REG_UNUSED, 64'hdeadbeefdeadbeef);
		dir_tbl = '{
			'{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b1,
				128'h69c4e0d86a7b0430d8cdb78070b4c55a}
		};
		foreach (dir_tbl[i])
			send_block(dir_tbl[i]);
		drain();
		write_reg(REG_DIRECTION, 64'h1);
		dir_tbl = '{
			'{1'b0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 5'd3, 1'b1,
				128'h00112233445566778899aabbccddeeff}
		};
		foreach (dir_tbl[i])
			send_block(dir_tbl[i]);
		drain();

		// CBC, both directions, IV with an all-ones and an all-zero half
		write_reg(REG_IV_HIGH, 64'hffffffffffffffff);
		write_reg(REG_IV_LOW, 64'h0);
		write_reg(REG_CHAIN_MODE, 64'h1);
		for (int i = 0; i < 6; i++)
			random_block(i == 0 ? 100 : 20);
		drain();
		write_reg(REG_DIRECTION, 64'h0);
		for (int i = 0; i < 6; i++)
			random_block(i == 0 ? 100 : 20);
		drain();

		// random phases with full back-pressure once
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_KEY_HIGH, {$urandom, $urandom});
			write_reg(REG_KEY_LOW, {$urandom, $urandom});
			write_reg(REG_IV_HIGH, {$urandom, $urandom});
			write_reg(REG_IV_LOW, {$urandom, $urandom});
			write_reg(REG_CHAIN_MODE, 64'(ph % 2));
			write_reg(REG_DIRECTION, 64'((ph / 2) % 2));
			if (ph == 3)
				long_hold = 1'b1;
			for (int i = 0; i < 110; i++)
				random_block(i == 0 ? 100 : 10);
			drain();
		end
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
